/* hdl/heavy_key_load_balancer_macros.svh */
// Assertion helpers shared by the balancer modules.
`ifndef HEAVY_KEY_LOAD_BALANCER_MACROS_SVH
`define HEAVY_KEY_LOAD_BALANCER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define HKLB_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Implication whose consequence is checked in the cycle after its antecedent.
`define HKLB_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

/* hdl/hklb_pkg.sv */
`default_nettype none
package hklb_pkg;
  localparam int unsigned NUM_ROWS = 3;
  localparam int unsigned NUM_PARTITIONS = 8;
  localparam logic [31:0] COUNT_MAX = 32'hffff_ffff;
  localparam logic [31:0] THRESHOLD_RESET = 32'd32;
  localparam logic [4:0] SHIFT_RESET = 5'd21;
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_SHIFT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;     // write zero at the clear address
    logic load;      // capture the input word and read the stores
    logic update;    // write back sketch rows, decide partition
    logic commit;    // write schedule on a new pick and load, raise result
  } hklb_cmd_t;

  typedef struct packed {
    logic clear_done;
  } hklb_status_t;

  function automatic logic [31:0] key_crc(input logic [31:0] key);
    logic [31:0] crc;
    crc = 32'd1;
    for (int b = 3; b >= 0; b--) begin
      crc = crc ^ {24'd0, key[8*b +: 8]};
      for (int i = 0; i < 8; i++) begin
        crc = crc[0] ? ((crc >> 1) ^ 32'hEDB8_8320) : (crc >> 1);
      end
    end
    return crc;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == COUNT_MAX) ? v : v + 32'd1;
  endfunction
endpackage
`default_nettype wire

/* hdl/heavy_key_load_balancer.sv */
`default_nettype none
// Count-min sketch request steering. Each word goes through steps in order: the
// stores are read first, then the sketch rows are written back and the partition
// chosen, and last the schedule entry and partition load are updated and the
// result is raised. The single read/write port of each memory is why these
// steps are separate. After reset the block clears its memories and takes no
// word meanwhile.
module heavy_key_load_balancer import hklb_pkg::*; #(
  parameter int unsigned SKETCH_WIDTH = 1024,
  parameter int unsigned SCHEDULE_ENTRIES = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] key_i,
  input  wire logic [31:0] timestamp_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      estimated_count_o,
  output logic [2:0]       target_partition_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  logic [31:0] threshold_q;
  logic [4:0] shift_q;
  hklb_cmd_t cmd;
  hklb_status_t status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
      shift_q <= SHIFT_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_THRESHOLD) threshold_q <= cfg_data_i;
      if (cfg_index_i == CFG_SHIFT) shift_q <= cfg_data_i[4:0];
    end
  end

  hklb_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .out_valid_i(out_valid_o), .out_ready_i,
    .status_i(status), .cmd_o(cmd)
  );

  hklb_datapath #(
    .SKETCH_WIDTH(SKETCH_WIDTH),
    .SCHEDULE_ENTRIES(SCHEDULE_ENTRIES)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .key_i, .timestamp_i, .threshold_i(threshold_q), .shift_i(shift_q),
    .out_ready_i, .out_valid_o, .estimated_count_o, .target_partition_o
  );
endmodule
`default_nettype wire

/* hdl/hklb_ctrl.sv */
`default_nettype none
`include "heavy_key_load_balancer_macros.svh"
module hklb_ctrl import hklb_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic         out_valid_i,
  input  wire logic         out_ready_i,
  input  hklb_status_t      status_i,
  output hklb_cmd_t         cmd_o
);
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_UPD   = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state_q, state_d;

  // A new word may enter while a result waits if the result leaves now.
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_i || out_ready_i);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `HKLB_ASSERT_NEXT(a_load_upd, clk_i, rst_ni, cmd_o.load, cmd_o.update)
  `HKLB_ASSERT_NEXT(a_upd_commit, clk_i, rst_ni, cmd_o.update, cmd_o.commit)
  `HKLB_ASSERT_IMP(a_no_ready_clear, clk_i, rst_ni, cmd_o.clear, !in_ready_o)
endmodule
`default_nettype wire

/* hdl/hklb_datapath.sv */
`default_nettype none
`include "heavy_key_load_balancer_macros.svh"
module hklb_datapath import hklb_pkg::*; #(
  parameter int unsigned SKETCH_WIDTH = 1024,
  parameter int unsigned SCHEDULE_ENTRIES = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  hklb_cmd_t        cmd_i,
  output hklb_status_t     status_o,
  input  wire logic [31:0] key_i,
  input  wire logic [31:0] timestamp_i,
  input  wire logic [31:0] threshold_i,
  input  wire logic [4:0]  shift_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic [31:0]      estimated_count_o,
  output logic [2:0]       target_partition_o
);
  localparam int unsigned SW = $clog2(SKETCH_WIDTH);
  localparam int unsigned SE = $clog2(SCHEDULE_ENTRIES);
  localparam int unsigned PW = $clog2(NUM_PARTITIONS);
  localparam int unsigned CW = (SW > SE) ? SW : SE;
  localparam logic [CW:0] SK_DEPTH = (CW+1)'(SKETCH_WIDTH);
  localparam logic [CW:0] SC_DEPTH = (CW+1)'(SCHEDULE_ENTRIES);

  // Three sketch rows, each a memory of count plus epoch.
  logic [34:0] row0_mem [SKETCH_WIDTH];
  logic [34:0] row1_mem [SKETCH_WIDTH];
  logic [34:0] row2_mem [SKETCH_WIDTH];
  logic [5:0]  sched_mem [SCHEDULE_ENTRIES];
  logic [31:0] loads_q [NUM_PARTITIONS];

  logic [CW:0] clr_q;
  logic [SW-1:0] idx0_q, idx1_q, idx2_q;
  logic [SE-1:0] hs_q;
  logic [2:0] epoch_q;
  logic [2:0] light_q;
  logic [34:0] rd0_q, rd1_q, rd2_q;
  logic [5:0] sched_rd_q;
  logic [31:0] est_q;
  logic [PW-1:0] part_q;
  logic new_pick_q;
  logic out_valid_q;

  logic [31:0] ts_sh;
  logic [11:0] ha, hb;
  logic [31:0] c0, c1, c2, m01, est_d;
  logic [PW-1:0] part_d, best_idx;
  logic [31:0] best_val;
  logic [31:0] crc;

  assign ts_sh = timestamp_i >> shift_i;
  assign ha = key_i[19:8];
  assign hb = key_i[31:20];
  assign crc = key_crc(key_i);
  assign status_o.clear_done = (clr_q[CW-1:0] == '1);

  assign c0 = (rd0_q[34:32] == epoch_q) ? sat_inc(rd0_q[31:0]) : 32'd1;
  assign c1 = (rd1_q[34:32] == epoch_q) ? sat_inc(rd1_q[31:0]) : 32'd1;
  assign c2 = (rd2_q[34:32] == epoch_q) ? sat_inc(rd2_q[31:0]) : 32'd1;
  assign m01 = (c1 < c0) ? c1 : c0;
  assign est_d = (c2 < m01) ? c2 : m01;

  always_comb begin
    best_val = COUNT_MAX;
    best_idx = '0;
    for (int i = 0; i < NUM_PARTITIONS; i++) begin
      if (loads_q[i] < best_val) begin
        best_val = loads_q[i];
        best_idx = PW'(i);
      end
    end
  end

  always_comb begin
    if (est_d < threshold_i) begin
      part_d = PW'({29'd0, light_q} % NUM_PARTITIONS);
    end else if (sched_rd_q[2:0] == epoch_q) begin
      part_d = PW'({29'd0, sched_rd_q[5:3]} % NUM_PARTITIONS);
    end else begin
      part_d = best_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      if (clr_q < SK_DEPTH) begin
        row0_mem[clr_q[SW-1:0]] <= '0;
        row1_mem[clr_q[SW-1:0]] <= '0;
        row2_mem[clr_q[SW-1:0]] <= '0;
      end
      if (clr_q < SC_DEPTH) sched_mem[clr_q[SE-1:0]] <= '0;
    end
    if (cmd_i.load) begin
      idx0_q <= SW'(ha ^ hb);
      idx1_q <= SW'(ha | hb);
      idx2_q <= SW'(ha & hb);
      hs_q <= crc[SE-1:0];
      epoch_q <= ts_sh[2:0];
      light_q <= key_i[18:16];
      rd0_q <= row0_mem[SW'(ha ^ hb)];
      rd1_q <= row1_mem[SW'(ha | hb)];
      rd2_q <= row2_mem[SW'(ha & hb)];
      sched_rd_q <= sched_mem[crc[SE-1:0]];
    end
    if (cmd_i.update) begin
      row0_mem[idx0_q] <= {epoch_q, c0};
      row1_mem[idx1_q] <= {epoch_q, c1};
      row2_mem[idx2_q] <= {epoch_q, c2};
      est_q <= est_d;
      part_q <= part_d;
      new_pick_q <= (est_d >= threshold_i) && (sched_rd_q[2:0] != epoch_q);
    end
    if (cmd_i.commit && new_pick_q) begin
      sched_mem[hs_q] <= {3'(part_q), epoch_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_PARTITIONS; i++) loads_q[i] <= '0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + 1'b1;
      if (cmd_i.commit) begin
        loads_q[part_q] <= sat_inc(loads_q[part_q]);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign estimated_count_o = est_q;
  assign target_partition_o = 3'(part_q);

  `HKLB_ASSERT_NEXT(a_commit_valid, clk_i, rst_ni, cmd_i.commit, out_valid_o)
  `HKLB_ASSERT_IMP(a_est_nonzero, clk_i, rst_ni, out_valid_o, estimated_count_o != 32'd0)
endmodule
`default_nettype wire
